// ===== hw/rtl/aau_pkg.sv =====
// Shared constants and types of the bounding-box accumulator.
`default_nettype none

package aau_pkg;

    localparam int CoordBitsDef = 32;
    localparam int FieldW       = 32;
    localparam int Lanes        = 3;

    localparam int InTdataW  = 2 * Lanes * FieldW;
    localparam int InTuserW  = 2;
    localparam int OutTdataW = (3 * Lanes + 1) * FieldW;
    localparam int OutTuserW = 1;

    localparam int QueueDepth = 2;

    localparam int ApbAddrW = 3;
    localparam int ApbDataW = 32;
    localparam int RegIdxW  = ApbAddrW - 2;

    localparam logic [RegIdxW-1:0] REG_SWAP_AXES = '0;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_SET    = 2'd1,
        ACT_VERTEX = 2'd2,
        ACT_UNION  = 2'd3
    } action_t;

endpackage

`default_nettype wire

// ===== hw/rtl/aau_front.sv =====
// Front end: unpacks an input item, applies the axis swap, classifies it.
`default_nettype none

module aau_front
    import aau_pkg::*;
#(
    parameter  int COORD_BITS = CoordBitsDef,
    localparam int ItemW      = 3 + 2 * Lanes * COORD_BITS
) (
    input  logic                swap_axes,
    input  logic [InTuserW-1:0] s_tuser,
    input  logic [InTdataW-1:0] s_tdata,
    output logic [ItemW-1:0]    item
);

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        action_t                action;
        logic                   op_empty;
        coord_t [Lanes-1:0]     a;
        coord_t [Lanes-1:0]     b;
    } item_t;

    coord_t [Lanes-1:0] raw_a;
    coord_t [Lanes-1:0] raw_b;
    item_t              item_c;

    // negation that saturates the least code to the greatest
    function automatic coord_t neg_sat(input coord_t v);
        if (v[COORD_BITS-1] && (v[COORD_BITS-2:0] == '0)) begin
            return ~v;
        end
        return -v;
    endfunction

    always_comb begin
        for (int i = 0; i < Lanes; i++) begin
            raw_a[i] = coord_t'(s_tdata[i*FieldW +: COORD_BITS]);
            raw_b[i] = coord_t'(s_tdata[(Lanes+i)*FieldW +: COORD_BITS]);
        end
        item_c.action   = action_t'(s_tuser);
        item_c.op_empty = (raw_a == raw_b);
        item_c.a        = raw_a;
        item_c.b        = raw_b;
        if (swap_axes) begin
            unique case (item_c.action)
                ACT_SET: begin
                    item_c.a[1] = raw_a[2];
                    item_c.a[2] = neg_sat(raw_b[1]);
                    item_c.b[1] = raw_b[2];
                    item_c.b[2] = neg_sat(raw_a[1]);
                end
                ACT_VERTEX: begin
                    item_c.a[1] = raw_a[2];
                    item_c.a[2] = neg_sat(raw_a[1]);
                end
                default: begin
                    // clear and union take no swap
                end
            endcase
        end
    end

    assign item = item_c;

endmodule

`default_nettype wire

// ===== hw/rtl/aau_queue.sv =====
// Small first-word-fall-through queue between front end and back end.
`default_nettype none

module aau_queue
    import aau_pkg::*;
#(
    parameter int Width = 8,
    parameter int Depth = QueueDepth
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [Width-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [Width-1:0] rd_data,
    output logic             empty
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    logic [Width-1:0] slot_reg [Depth];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        if (p == PtrW'(Depth - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = slot_reg[rd_ptr_reg];
    assign full    = (count_reg == CntW'(Depth));
    assign empty   = (count_reg == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/aau_isqrt.sv =====
// Bit-serial integer square root, one root bit per cycle.
`default_nettype none

module aau_isqrt
    import aau_pkg::*;
#(
    parameter  int RootW = CoordBitsDef,
    localparam int OpW   = 2 * RootW
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [OpW-1:0]   operand,
    output logic             done,
    output logic [RootW-1:0] root
);

    localparam int CntW = $clog2(RootW + 1);

    logic             busy_reg, busy_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic [OpW-1:0]   op_reg, op_next;
    logic [RootW:0]   rem_reg, rem_next;
    logic [RootW-1:0] root_reg, root_next;

    logic [RootW+2:0] rem_sh;
    logic [RootW+2:0] trial;
    logic [RootW+2:0] diff;

    always_comb begin
        rem_sh    = {rem_reg, op_reg[OpW-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        diff      = rem_sh - trial;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CntW'(RootW);
            op_next   = operand;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            op_next  = op_reg << 2;
            cnt_next = cnt_reg - 1'b1;
            if (rem_sh >= trial) begin
                rem_next  = diff[RootW:0];
                root_next = {root_reg[RootW-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh[RootW:0];
                root_next = {root_reg[RootW-2:0], 1'b0};
            end
            if (cnt_reg == CntW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    // high during the last step; root is final on the following cycle
    assign done = busy_reg && (cnt_reg == CntW'(1));
    assign root = root_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/aau_back.sv =====
// Back end: box update, center, squared distance, root, result register.
`default_nettype none

module aau_back
    import aau_pkg::*;
#(
    parameter  int COORD_BITS = CoordBitsDef,
    localparam int ItemW      = 3 + 2 * Lanes * COORD_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_empty,
    input  logic [ItemW-1:0]     q_data,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OutTdataW-1:0] m_tdata,
    output logic [OutTuserW-1:0] m_tuser
);

    localparam int SqW = 2 * COORD_BITS;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        action_t                action;
        logic                   op_empty;
        coord_t [Lanes-1:0]     a;
        coord_t [Lanes-1:0]     b;
    } item_t;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_UPD  = 7'b0000010,
        ST_MID  = 7'b0000100,
        ST_MAG  = 7'b0001000,
        ST_SQ   = 7'b0010000,
        ST_ROOT = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    localparam coord_t CoordMax = coord_t'({1'b0, {(COORD_BITS-1){1'b1}}});
    localparam coord_t CoordMin = ~CoordMax;

    state_t                        state_reg, state_next;
    item_t                         item_reg, item_next;
    coord_t [Lanes-1:0]            low_reg, low_next;
    coord_t [Lanes-1:0]            high_reg, high_next;
    logic                          changed_reg, changed_next;
    coord_t [Lanes-1:0]            mid_reg, mid_next;
    logic [Lanes-1:0][COORD_BITS-1:0] mag_reg, mag_next;
    logic [1:0]                    lane_reg, lane_next;
    logic [SqW-1:0]                prod_reg, prod_next;
    logic [SqW-1:0]                acc_reg, acc_next;
    logic                          root_start_reg, root_start_next;
    logic                          m_valid_reg, m_valid_next;
    logic [OutTdataW-1:0]          m_data_reg, m_data_next;
    logic [OutTuserW-1:0]          m_user_reg, m_user_next;

    logic                          cur_empty;
    logic [COORD_BITS-1:0]         mag_sel;
    logic [SqW-1:0]                sq_c;
    logic signed [COORD_BITS:0]    half_sum;
    logic signed [COORD_BITS:0]    delta;
    logic signed [COORD_BITS:0]    delta_neg;
    logic                          root_done;
    logic [COORD_BITS-1:0]         root_val;

    aau_isqrt #(
        .RootW (COORD_BITS)
    ) u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (root_start_reg),
        .operand (acc_reg),
        .done    (root_done),
        .root    (root_val)
    );

    assign cur_empty = (low_reg == high_reg);

    always_comb begin
        unique case (lane_reg)
            2'd0:    mag_sel = mag_reg[0];
            2'd1:    mag_sel = mag_reg[1];
            2'd2:    mag_sel = mag_reg[2];
            default: mag_sel = '0;
        endcase
    end

    assign sq_c = mag_sel * mag_sel;

    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        changed_next    = changed_reg;
        mid_next        = mid_reg;
        mag_next        = mag_reg;
        lane_next       = lane_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        root_start_next = 1'b0;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        q_pop           = 1'b0;
        half_sum        = '0;
        delta           = '0;
        delta_neg       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    item_next  = item_t'(q_data);
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                changed_next = 1'b0;
                unique case (item_reg.action)
                    ACT_CLEAR: begin
                        low_next  = '0;
                        high_next = '0;
                    end
                    ACT_SET: begin
                        low_next  = item_reg.a;
                        high_next = item_reg.b;
                    end
                    ACT_VERTEX: begin
                        for (int i = 0; i < Lanes; i++) begin
                            if ($signed(item_reg.a[i]) < $signed(low_reg[i])) begin
                                low_next[i] = item_reg.a[i];
                            end
                            if ($signed(item_reg.a[i]) > $signed(high_reg[i])) begin
                                high_next[i] = item_reg.a[i];
                            end
                        end
                    end
                    ACT_UNION: begin
                        if (cur_empty) begin
                            // a zero-size box (min equal to max in every lane) is replaced outright
                            changed_next = 1'b1;
                            low_next     = item_reg.a;
                            high_next    = item_reg.b;
                        end else if (!item_reg.op_empty) begin
                            for (int i = 0; i < Lanes; i++) begin
                                if ($signed(item_reg.a[i]) < $signed(low_reg[i])) begin
                                    changed_next = 1'b1;
                                    low_next[i]  = item_reg.a[i];
                                end
                                if ($signed(item_reg.b[i]) > $signed(high_reg[i])) begin
                                    changed_next = 1'b1;
                                    high_next[i] = item_reg.b[i];
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                state_next = ST_MID;
            end
            ST_MID: begin
                // floor of the half sum: arithmetic shift of the wide sum
                for (int i = 0; i < Lanes; i++) begin
                    half_sum    = {low_reg[i][COORD_BITS-1], low_reg[i]}
                                + {high_reg[i][COORD_BITS-1], high_reg[i]};
                    mid_next[i] = half_sum[COORD_BITS:1];
                end
                state_next = ST_MAG;
            end
            ST_MAG: begin
                for (int i = 0; i < Lanes; i++) begin
                    delta       = {high_reg[i][COORD_BITS-1], high_reg[i]}
                                - {mid_reg[i][COORD_BITS-1], mid_reg[i]};
                    delta_neg   = -delta;
                    mag_next[i] = delta[COORD_BITS] ? delta_neg[COORD_BITS-1:0]
                                                    : delta[COORD_BITS-1:0];
                end
                lane_next  = '0;
                state_next = ST_SQ;
            end
            ST_SQ: begin
                // one square per cycle, each accumulated in the cycle after it is formed
                prod_next = sq_c;
                acc_next  = (lane_reg == 2'd0) ? '0 : acc_reg + prod_reg;
                lane_next = lane_reg + 1'b1;
                if (lane_reg == 2'd3) begin
                    root_start_next = 1'b1;
                    state_next      = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (root_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    for (int i = 0; i < Lanes; i++) begin
                        m_data_next[i*FieldW +: FieldW] = FieldW'($signed(low_reg[i]));
                        m_data_next[(Lanes+i)*FieldW +: FieldW] =
                            FieldW'($signed(high_reg[i]));
                        m_data_next[(2*Lanes+i)*FieldW +: FieldW] =
                            FieldW'($signed(mid_reg[i]));
                    end
                    m_data_next[3*Lanes*FieldW +: FieldW] = FieldW'(root_val);
                    m_user_next = OutTuserW'(changed_reg);
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            low_reg        <= {Lanes{CoordMax}};
            high_reg       <= {Lanes{CoordMin}};
            changed_reg    <= 1'b0;
            lane_reg       <= '0;
            root_start_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            changed_reg    <= changed_next;
            lane_reg       <= lane_next;
            root_start_reg <= root_start_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        mid_reg    <= mid_next;
        mag_reg    <= mag_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/aabb_accumulate_union_top.sv =====
// Usage: bounding-box accumulator with center and bounding-sphere radius.
//   s_axis: one item per action (clear, set box, add vertex, union with box);
//     the action travels in tuser, the two corner points in tdata.
//   m_axis: one result per item: box min/max, center, radius in tdata,
//     the union changed flag in tuser.
//   APB: one register, swap_axes at byte address 0; write it only while idle.
// Timing: the back end works on one item at a time, and the bit-serial square root,
//   one root bit per cycle, is the longest step of its work.
// A two-entry queue parts the front end from the back end, so up to two more
//   items are taken while one is in work. With m_axis_tready low the result
//   register holds its item, the back end finishes the next one and waits,
//   and s_axis_tready drops once the queue is full.
// Reset (aresetn low, synchronous): the box goes to the empty inverted state
//   (min at the greatest code, max at the least), swap_axes to 0, queue empty.
`default_nettype none

module aabb_accumulate_union_top
    import aau_pkg::*;
#(
    parameter int COORD_BITS = CoordBitsDef
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z
    input  logic [InTdataW-1:0]  s_axis_tdata,
    // action
    input  logic [InTuserW-1:0]  s_axis_tuser,

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // low_x, low_y, low_z, high_x, high_y, high_z, mid_x, mid_y, mid_z, radius
    output logic [OutTdataW-1:0] m_axis_tdata,
    // changed
    output logic [OutTuserW-1:0] m_axis_tuser,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ApbAddrW-1:0]  paddr,
    input  logic [ApbDataW-1:0]  pwdata,
    output logic [ApbDataW-1:0]  prdata,
    output logic                 pready
);

    localparam int ItemW = 3 + 2 * Lanes * COORD_BITS;

    logic             swap_reg, swap_next;
    logic             cfg_hit;
    logic [ItemW-1:0] front_item;
    logic [ItemW-1:0] q_data;
    logic             q_full;
    logic             q_empty;
    logic             q_push;
    logic             q_pop;

    // register file: one bit, word-addressed
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[ApbAddrW-1:2] == REG_SWAP_AXES);
    assign prdata  = (psel && cfg_hit) ? ApbDataW'(swap_reg) : '0;

    always_comb begin
        swap_next = swap_reg;
        if (psel && penable && pwrite && pready && cfg_hit) begin
            swap_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            swap_reg <= 1'b0;
        end else begin
            swap_reg <= swap_next;
        end
    end

    // front end classifies straight into the queue
    aau_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .swap_axes (swap_reg),
        .s_tuser   (s_axis_tuser),
        .s_tdata   (s_axis_tdata),
        .item      (front_item)
    );

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    aau_queue #(
        .Width (ItemW),
        .Depth (QueueDepth)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (front_item),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    aau_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/aau_chk.sv =====
// Port-level checker for the bounding-box accumulator, bound to the top level.
`default_nettype none

module aau_chk
    import aau_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [OutTdataW-1:0] m_axis_tdata,
    input logic [OutTuserW-1:0] m_axis_tuser,
    input logic                 psel,
    input logic                 penable,
    input logic                 pwrite,
    input logic [ApbAddrW-1:0]  paddr,
    input logic [ApbDataW-1:0]  pwdata,
    input logic [ApbDataW-1:0]  prdata,
    input logic                 pready
);

    logic signed [FieldW:0] half_sum [Lanes];
    logic                   mid_ok;
    logic                   swap_wr;
    logic                   swap_rd;

    always_comb begin
        mid_ok = 1'b1;
        for (int i = 0; i < Lanes; i++) begin
            half_sum[i] = {m_axis_tdata[i*FieldW + FieldW - 1], m_axis_tdata[i*FieldW +: FieldW]}
                        + {m_axis_tdata[(Lanes+i)*FieldW + FieldW - 1],
                           m_axis_tdata[(Lanes+i)*FieldW +: FieldW]};
            if (m_axis_tdata[(2*Lanes+i)*FieldW +: FieldW] != half_sum[i][FieldW:1]) begin
                mid_ok = 1'b0;
            end
        end
    end

    assign swap_wr = psel && penable && pwrite && pready
                     && (paddr[ApbAddrW-1:2] == REG_SWAP_AXES);
    assign swap_rd = psel && !pwrite && (paddr[ApbAddrW-1:2] == REG_SWAP_AXES);

    // no result survives reset; the queue is open right after it
    a_reset_clean: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid && s_axis_tready)
        else $error("output valid or input blocked after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // the center is the floored half sum of the reported corners
    a_mid_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> mid_ok)
        else $error("center does not match box corners");

    // a register write reads back on the next cycle
    a_cfg_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        swap_wr ##1 swap_rd |-> prdata[0] == $past(pwdata[0]))
        else $error("swap_axes readback mismatch");

endmodule

bind aabb_accumulate_union_top aau_chk u_aau_chk (.*);

`default_nettype wire

// ===== sim/tb_aabb_accumulate_union_top.sv =====
// Self-checking testbench of the bounding-box accumulator: directed and random items, APB setup.

// Tracks the box the block should hold and the results it owes.
class box_checker;
    localparam logic signed [31:0] CMAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] CMIN = 32'sh8000_0000;

    logic signed [31:0] box_lo[3];
    logic signed [31:0] box_hi[3];
    bit                 swap_on;
    logic [319:0]       due_boxes[$];
    bit                 due_changed[$];
    int                 errors;
    string              field_name[10];

    function new();
        field_name = '{"low_x", "low_y", "low_z", "high_x", "high_y", "high_z",
                       "mid_x", "mid_y", "mid_z", "radius"};
        for (int i = 0; i < 3; i++) begin
            box_lo[i] = CMAX;
            box_hi[i] = CMIN;
        end
        swap_on = 1'b0;
        errors  = 0;
    endfunction

    function void set_swap(bit value);
        swap_on = value;
    endfunction

    function int pending();
        return due_boxes.size();
    endfunction

    static function logic signed [31:0] neg_sat(logic signed [31:0] v);
        if (v == CMIN)
            return CMAX;
        return -v;
    endfunction

    // bit-pair integer square root
    static function longint unsigned root64(longint unsigned arg);
        longint unsigned n, res, bitv;
        n    = arg;
        res  = 0;
        bitv = 64'h1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function void take_item(logic [1:0] act_bits, logic [191:0] pts);
        logic signed [31:0] a[3], b[3], v[3], mid[3];
        longint             sum2, d;
        longint unsigned    acc, mag, root;
        bit                 chg, cur_empty, op_empty;
        logic [319:0]       r;
        acc = 0;
        chg = 1'b0;
        for (int i = 0; i < 3; i++) begin
            a[i] = pts[32*i +: 32];
            b[i] = pts[96 + 32*i +: 32];
        end
        case (aau_pkg::action_t'(act_bits))
            aau_pkg::ACT_CLEAR: begin
                for (int i = 0; i < 3; i++) begin
                    box_lo[i] = '0;
                    box_hi[i] = '0;
                end
            end
            aau_pkg::ACT_SET: begin
                if (swap_on) begin
                    // (x,y,z) -> (x,z,-y): the negated y bounds trade places
                    box_lo = '{a[0], a[2], neg_sat(b[1])};
                    box_hi = '{b[0], b[2], neg_sat(a[1])};
                end else begin
                    box_lo = a;
                    box_hi = b;
                end
            end
            aau_pkg::ACT_VERTEX: begin
                if (swap_on)
                    v = '{a[0], a[2], neg_sat(a[1])};
                else
                    v = a;
                for (int i = 0; i < 3; i++) begin
                    if (v[i] < box_lo[i]) box_lo[i] = v[i];
                    if (v[i] > box_hi[i]) box_hi[i] = v[i];
                end
            end
            aau_pkg::ACT_UNION: begin
                // operand is already in block coordinates, no swap
                cur_empty = (box_lo[0] == box_hi[0]) && (box_lo[1] == box_hi[1])
                            && (box_lo[2] == box_hi[2]);
                op_empty  = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
                if (cur_empty) begin
                    chg    = 1'b1;
                    box_lo = a;
                    box_hi = b;
                end else if (!op_empty) begin
                    for (int i = 0; i < 3; i++) begin
                        if (a[i] < box_lo[i]) begin chg = 1'b1; box_lo[i] = a[i]; end
                        if (b[i] > box_hi[i]) begin chg = 1'b1; box_hi[i] = b[i]; end
                    end
                end
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            sum2   = longint'(box_lo[i]) + longint'(box_hi[i]);
            mid[i] = 32'(sum2 >>> 1);
            d      = longint'(box_hi[i]) - longint'(mid[i]);
            mag    = (d < 0) ? longint'(-d) : d;
            acc    = acc + mag * mag;
            r[32*i +: 32]       = box_lo[i];
            r[96 + 32*i +: 32]  = box_hi[i];
            r[192 + 32*i +: 32] = mid[i];
        end
        root = root64(acc);
        r[288 +: 32] = root[31:0];
        due_boxes.push_back(r);
        due_changed.push_back(chg);
    endfunction

    function void match_result(logic [319:0] data, logic chg);
        logic [319:0] want;
        bit           want_chg;
        if (due_boxes.size() == 0) begin
            $display("%0t: result with nothing expected: %h", $time, data);
            errors++;
            return;
        end
        want     = due_boxes.pop_front();
        want_chg = due_changed.pop_front();
        for (int i = 0; i < 10; i++) begin
            if (data[32*i +: 32] !== want[32*i +: 32]) begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, field_name[i],
                         want[32*i +: 32], data[32*i +: 32]);
                errors++;
            end
        end
        if (chg !== want_chg) begin
            $display("%0t: changed mismatch: expected %b, actual %b", $time, want_chg, chg);
            errors++;
        end
    endfunction
endclass

module tb_aabb_accumulate_union_top;
    import aau_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W     = 32;
    localparam int SETTLE      = 60;     // longer than the back end takes for one item
    localparam int HOLD_CYCLES = 300;    // long receiver stall, fills the input queue
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 220;

    localparam logic signed [31:0] CMAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] CMIN = 32'sh8000_0000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [InTdataW-1:0]  s_axis_tdata;
    logic [InTuserW-1:0]  s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OutTdataW-1:0] m_axis_tdata;
    logic [OutTuserW-1:0] m_axis_tuser;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ApbAddrW-1:0]  paddr;
    logic [ApbDataW-1:0]  pwdata;
    logic [ApbDataW-1:0]  prdata;
    logic                 pready;

    box_checker sb;

    // per-phase idle limits of both sides; 0 gives a stretch with no idling
    int tx_max_gap;
    int rx_max_gap;
    bit hold_off_req;

    aabb_accumulate_union_top #(
        .COORD_BITS(COORD_W)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Both monitors sample at the edge, so they see pre-edge values of the handshake.
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready)
            sb.take_item(s_axis_tuser, s_axis_tdata);
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.match_result(m_axis_tdata, m_axis_tuser[0]);
    end

    // tdata layout: first_x/y/z in the low 96 bits, second_x/y/z above
    function automatic logic [191:0] pts6(logic signed [31:0] ax, logic signed [31:0] ay,
                                          logic signed [31:0] az, logic signed [31:0] bx,
                                          logic signed [31:0] by, logic signed [31:0] bz);
        return {bz, by, bx, az, ay, ax};
    endfunction

    // Mostly extremes and small values, so boxes overlap and union has real work;
    // a share of full-width values toggles every bit.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return CMIN;
            1:       return CMAX;
            2:       return '0;
            3:       return '1;
            4, 5, 6: return 32'($urandom_range(0, 2000)) - 32'd1000;
            default: return $urandom();
        endcase
    endfunction

    // Offers one item after a random idle gap; returns once s_axis_tready reads high after an edge.
    task automatic send_item(action_t act, logic [191:0] pts);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pts;
        s_axis_tuser  <= act;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    // Random item with a bias toward well-formed boxes: sorted min/max most of the time,
    // some zero-size operands and boxes, clears now and then to reach the empty-box path.
    task automatic send_random_item();
        int            pick;
        logic [31:0]   a[3], b[3], t;
        action_t       act;
        pick = $urandom_range(0, 99);
        if (pick < 6)       act = ACT_CLEAR;
        else if (pick < 20) act = ACT_SET;
        else if (pick < 60) act = ACT_VERTEX;
        else                act = ACT_UNION;
        for (int i = 0; i < 3; i++) begin
            a[i] = rand_coord();
            b[i] = rand_coord();
        end
        if ((act == ACT_SET || act == ACT_UNION) && $urandom_range(0, 9) < 8) begin
            for (int i = 0; i < 3; i++) begin
                if ($signed(a[i]) > $signed(b[i])) begin
                    t    = a[i];
                    a[i] = b[i];
                    b[i] = t;
                end
            end
        end
        if ((act == ACT_UNION && $urandom_range(0, 4) == 0)
            || (act == ACT_SET && $urandom_range(0, 9) == 0))
            b = a;
        send_item(act, {b[2], b[1], b[0], a[2], a[1], a[0]});
    endtask

    // Write swap_axes, then read it back. Only called while the block is idle.
    task automatic write_swap_axes(bit value);
        logic [ApbDataW-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_SWAP_AXES, 2'b00};
        pwdata  <= ApbDataW'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.set_swap(value);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== ApbDataW'(value)) begin
            $display("%0t: swap_axes readback mismatch: expected %h, actual %h", $time,
                     ApbDataW'(value), rd);
            sb.errors++;
        end
    endtask

    // Let the block run dry, then give the back end its latency before anything else.
    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Receiver: random ready gaps per item, and one long hold-off on request.
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            gap = $urandom_range(0, rx_max_gap);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
        end
    end

    initial begin
        sb            = new();
        tx_max_gap    = 4;
        rx_max_gap    = 4;
        hold_off_req  = 1'b0;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed, swap_axes at its reset value ---
        // zero-size operand on the inverted reset box: box kept, reset state shows up
        send_item(ACT_UNION, pts6(5, 6, 7, 5, 6, 7));
        send_item(ACT_VERTEX, pts6(0, 0, 0, 0, 0, 0));
        // current box is zero-size: operand replaces it
        send_item(ACT_UNION, pts6(-10, -20, -30, 10, 20, 30));
        send_item(ACT_UNION, pts6(-1, -1, -1, 1, 1, 1));
        send_item(ACT_UNION, pts6(-11, 0, 0, 1, 1, 1));
        send_item(ACT_CLEAR, pts6(CMAX, CMIN, -1, CMAX, CMIN, -1));
        // empty box, operand equal to it: still counts as changed
        send_item(ACT_UNION, pts6(0, 0, 0, 0, 0, 0));
        send_item(ACT_SET, pts6(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
        // min above max goes in as given
        send_item(ACT_SET, pts6(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
        send_item(ACT_VERTEX, pts6(CMIN, CMAX, 0, 0, 0, 0));
        send_item(ACT_SET, pts6(0, 0, 0, 0, 0, 0));
        send_item(ACT_VERTEX, pts6(CMAX, CMAX, CMAX, 0, 0, 0));
        send_item(ACT_VERTEX, pts6(CMIN, CMIN, CMIN, 0, 0, 0));
        send_item(ACT_SET, pts6(-1, -1, -1, -1, -1, -1));
        wait_all_results();

        // --- directed, axes swapped ---
        write_swap_axes(1'b1);
        send_item(ACT_SET, pts6(1, 2, 3, 4, 5, 6));
        // negating the least code saturates
        send_item(ACT_SET, pts6(-5, CMIN, -7, 5, CMAX, 7));
        send_item(ACT_VERTEX, pts6(7, CMIN, 9, 0, 0, 0));
        send_item(ACT_VERTEX, pts6(CMAX, CMAX, CMIN, 0, 0, 0));
        // union operand bypasses the swap
        send_item(ACT_UNION, pts6(-100, -100, -100, 100, 100, 100));
        send_item(ACT_CLEAR, pts6(0, 0, 0, 0, 0, 0));
        send_item(ACT_VERTEX, pts6(1, 2, 3, 0, 0, 0));
        wait_all_results();

        // --- random phases: swap toggles, idle patterns change, one long stall ---
        for (int p = 0; p < PHASES; p++) begin
            write_swap_axes(p[0]);
            tx_max_gap = (p == 2 || p == 5) ? 0 : 4;
            rx_max_gap = (p == 2 || p == 6) ? 0 : 4;
            if (p == 3)
                hold_off_req = 1'b1;
            repeat (PHASE_ITEMS) send_random_item();
            wait_all_results();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: several times the slowest expected run.
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== aabb_accumulate_union_top.f =====
hw/rtl/aau_pkg.sv
hw/rtl/aau_front.sv
hw/rtl/aau_queue.sv
hw/rtl/aau_isqrt.sv
hw/rtl/aau_back.sv
hw/rtl/aabb_accumulate_union_top.sv
hw/rtl/aau_chk.sv
sim/tb_aabb_accumulate_union_top.sv
